// ----- rtl/slfpf_pkg.sv -----
// Shared types and constants for the sliding linear-fit peak finder.
package slfpf_pkg;

    // Result kind codes
    typedef logic [1:0] t_kind;

    localparam t_kind KIND_FILT = 2'd0;
    localparam t_kind KIND_RISE = 2'd1;
    localparam t_kind KIND_FALL = 2'd2;
    localparam t_kind KIND_PEAK = 2'd3;

    // Fixed widths of the item fields
    localparam int IN_W      = 16;
    localparam int POS_W     = 16;
    localparam int SUM_OUT_W = 21;
    localparam int MOM_OUT_W = 23;

endpackage

// ----- rtl/slfpf_ram.sv -----
// Generic single-port-write, registered-read RAM (read-first on a collision).
module slfpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the entry; a read of the same entry returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sliding_linear_fit_peak_finder_unit.sv -----
// Top level: sliding window sum and first moment, rise/fall/peak trackers and reports.
// A sample passes through stage 1, stage 2 (the result sequencer) and the output register;
// a filter result comes only once the window is full. Throughput is one sample per cycle
// while the input is not stalled, set by the single RAM port pair of the window buffer; a
// sample marked last also emits three reports, one per cycle while i_stall is low, and the
// input stalls whenever a sample that needs the result sequencer finds it still busy.
// Reset (i_rst_n, synchronous, active low) empties the window, clears the running sums, the
// trackers and all valid flags; the window RAM is not cleared, its entries are written first.
module sliding_linear_fit_peak_finder_unit
    import slfpf_pkg::*;
#(
    parameter int HALF_WIDTH  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [IN_W-1:0]      i_sample,
    input  logic [IN_W-1:0]      i_scan_offset,
    input  logic                 i_last,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_kind,
    output logic [POS_W-1:0]     o_position,
    output logic [SUM_OUT_W-1:0] o_window_sum,
    output logic [MOM_OUT_W-1:0] o_moment,
    output logic                 o_found,
    output logic                 o_run_end
);

    localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
    localparam int PTR_W   = $clog2(WIN_LEN);
    localparam int USE_W   = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WIN_LEN + 1);
    localparam int MOM_W   = SAMPLE_BITS + $clog2(HALF_WIDTH * (HALF_WIDTH + 1) / 2 + 1) + 1;
    localparam int COEF_W  = $clog2(HALF_WIDTH + 1) + 1;
    localparam int CALC_W  = ((SUM_W > MOM_W) ? SUM_W : MOM_W) + 2;

    // Window write side
    logic [PTR_W-1:0]       r_ptr;
    logic                   r_full;
    logic [POS_W-1:0]       r_center;

    // Stage 1: sample waiting for the oldest window entry
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_x;
    logic                   r_s1_slide;
    logic                   r_s1_last;
    logic signed [COEF_W-1:0] r_s1_coef;
    logic [POS_W-1:0]       r_s1_pos;

    // Running sums
    logic [SUM_W-1:0]        r_sum;
    logic signed [MOM_W-1:0] r_mom;

    // Stage 2: result sequencer
    logic                    r_s2_valid;
    logic                    r_s2_filt;
    logic                    r_s2_last;
    logic [SUM_W-1:0]        r_s2_sum;
    logic signed [MOM_W-1:0] r_s2_mom;
    logic signed [MOM_W-1:0] r_s2_prev;
    logic [POS_W-1:0]        r_s2_pos;
    t_kind                   r_cur;

    // Trackers
    logic                    r_rise_v;
    logic [POS_W-1:0]        r_rise_pos;
    logic signed [MOM_W-1:0] r_rise_val;
    logic                    r_fall_v;
    logic [POS_W-1:0]        r_fall_pos;
    logic signed [MOM_W-1:0] r_fall_val;
    logic                    r_peak_v;
    logic [POS_W-1:0]        r_peak_pos;
    logic [SUM_W-1:0]        r_peak_val;

    // Output register
    logic                    r_o_valid;
    t_kind                   r_o_kind;
    logic [POS_W-1:0]        r_o_pos;
    logic [SUM_OUT_W-1:0]    r_o_sum;
    logic [MOM_OUT_W-1:0]    r_o_mom;
    logic                    r_o_found;
    logic                    r_o_end;

    logic                   accept;
    logic                   out_load;
    logic                   emit;
    logic                   s2_done;
    logic                   s2_free;
    logic                   s1_to_s2;
    logic                   s1_adv;
    logic [SAMPLE_BITS-1:0] x_in;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [PTR_W-1:0]       ptr_inc;

    logic signed [CALC_W-1:0] c_x;
    logic signed [CALC_W-1:0] c_lo;
    logic signed [CALC_W-1:0] c_s;
    logic signed [CALC_W-1:0] c_m;
    logic signed [CALC_W-1:0] c_coef;
    logic signed [CALC_W-1:0] c_h;
    logic signed [CALC_W-1:0] n_sum_c;
    logic signed [CALC_W-1:0] n_mom_c;
    logic [SUM_W-1:0]         n_sum;
    logic signed [MOM_W-1:0]  n_mom;

    logic                    rise_upd;
    logic                    fall_upd;
    logic                    peak_upd;
    logic                    rise_found;
    logic                    fall_found;
    logic                    peak_found;
    logic [POS_W-1:0]        f_pos;
    logic [SUM_OUT_W-1:0]    f_sum;
    logic [MOM_OUT_W-1:0]    f_mom;
    logic                    f_found;

    function automatic logic [SUM_OUT_W-1:0] sum_field(input logic [SUM_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[SUM_OUT_W-1:0];
    endfunction

    function automatic logic [MOM_OUT_W-1:0] mom_field(input logic signed [MOM_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[MOM_OUT_W-1:0];
    endfunction

    // Flow control from the output register back to the input
    assign out_load = !r_o_valid || !i_stall;
    assign emit     = r_s2_valid && out_load;
    assign s2_done  = (r_cur == KIND_PEAK) || ((r_cur == KIND_FILT) && !r_s2_last);
    assign s2_free  = !r_s2_valid || (emit && s2_done);
    assign s1_to_s2 = r_s1_slide || r_s1_last;
    assign s1_adv   = r_s1_valid && (!s1_to_s2 || s2_free);
    assign o_stall  = r_s1_valid && !s1_adv;
    assign accept   = i_valid && !o_stall;

    assign x_in    = SAMPLE_BITS'(i_sample[USE_W-1:0]);
    assign ptr_inc = (r_ptr == PTR_W'(WIN_LEN - 1)) ? '0 : r_ptr + 1'b1;

    // Window buffer: write the new sample over the oldest, reading the oldest first
    slfpf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WIN_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_ptr),
        .i_wdata (x_in),
        .i_re    (accept && r_full),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // Advance the write pointer, fill state and window center
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_ptr  <= '0;
                r_full <= 1'b0;
            end else begin
                r_ptr <= ptr_inc;
                if (!r_full && (r_ptr == PTR_W'(WIN_LEN - 1))) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_full && (r_ptr == '0)) begin
                r_center <= i_scan_offset + POS_W'(HALF_WIDTH);
            end else if (r_full) begin
                r_center <= r_center + 1'b1;
            end
        end
    end

    // Stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !s1_adv);
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x     <= x_in;
            r_s1_slide <= r_full;
            r_s1_last  <= i_last;
            r_s1_coef  <= COEF_W'(r_ptr) - COEF_W'(HALF_WIDTH);
            r_s1_pos   <= r_center + 1'b1;
        end
    end

    // Update the window sum and first moment
    always_comb begin
        c_x    = CALC_W'(r_s1_x);
        c_lo   = CALC_W'(ram_rdata);
        c_s    = CALC_W'(r_sum);
        c_m    = CALC_W'(r_mom);
        c_coef = CALC_W'(r_s1_coef);
        c_h    = CALC_W'(HALF_WIDTH);
        if (r_s1_slide) begin
            n_sum_c = c_s + c_x - c_lo;
            n_mom_c = c_m + c_h * (c_x + c_lo) - (c_s - c_lo);
        end else begin
            n_sum_c = c_s + c_x;
            n_mom_c = c_m + c_coef * c_x;
        end
        n_sum = n_sum_c[SUM_W-1:0];
        n_mom = n_mom_c[MOM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_mom <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_sum <= '0;
                r_mom <= '0;
            end else begin
                r_sum <= n_sum;
                r_mom <= n_mom;
            end
        end
    end

    // Stage 2 control: hold the item until its last result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_cur      <= KIND_FILT;
        end else if (s1_adv && s1_to_s2) begin
            r_s2_valid <= 1'b1;
            r_cur      <= r_s1_slide ? KIND_FILT : KIND_RISE;
        end else if (emit) begin
            if (s2_done) begin
                r_s2_valid <= 1'b0;
            end else begin
                r_cur <= t_kind'(r_cur + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_to_s2) begin
            r_s2_filt <= r_s1_slide;
            r_s2_last <= r_s1_last;
            r_s2_sum  <= n_sum;
            r_s2_mom  <= n_mom;
            r_s2_prev <= r_mom;
            r_s2_pos  <= r_s1_pos;
        end
    end

    // Tracker decisions; ties keep the earlier point
    assign rise_upd = !r_rise_v || (r_s2_mom > r_rise_val);
    assign fall_upd = !r_fall_v || (r_s2_mom < r_fall_val);
    assign peak_upd = r_s2_mom[MOM_W-1] && !r_s2_prev[MOM_W-1] && (r_s2_prev != '0)
                      && (!r_peak_v || (r_s2_sum > r_peak_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_v <= 1'b0;
            r_fall_v <= 1'b0;
            r_peak_v <= 1'b0;
        end else if (emit) begin
            if (r_cur == KIND_PEAK) begin
                r_rise_v <= 1'b0;
                r_fall_v <= 1'b0;
                r_peak_v <= 1'b0;
            end else if (r_cur == KIND_FILT) begin
                if (rise_upd) begin
                    r_rise_v <= 1'b1;
                end
                if (fall_upd) begin
                    r_fall_v <= 1'b1;
                end
                if (peak_upd) begin
                    r_peak_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && (r_cur == KIND_FILT)) begin
            if (rise_upd) begin
                r_rise_pos <= r_s2_pos;
                r_rise_val <= r_s2_mom;
            end
            if (fall_upd) begin
                r_fall_pos <= r_s2_pos;
                r_fall_val <= r_s2_mom;
            end
            if (peak_upd) begin
                r_peak_pos <= r_s2_pos;
                r_peak_val <= r_s2_sum;
            end
        end
    end

    // Select the fields of the current result
    assign rise_found = r_rise_v && !r_rise_val[MOM_W-1] && (r_rise_val != '0);
    assign fall_found = r_fall_v && r_fall_val[MOM_W-1];
    assign peak_found = r_peak_v && (r_peak_val != '0);

    always_comb begin
        case (r_cur)
            KIND_FILT: begin
                f_pos   = r_s2_pos;
                f_sum   = sum_field(r_s2_sum);
                f_mom   = mom_field(r_s2_mom);
                f_found = 1'b0;
            end
            KIND_RISE: begin
                f_pos   = rise_found ? r_rise_pos : '0;
                f_sum   = '0;
                f_mom   = rise_found ? mom_field(r_rise_val) : '0;
                f_found = rise_found;
            end
            KIND_FALL: begin
                f_pos   = fall_found ? r_fall_pos : '0;
                f_sum   = '0;
                f_mom   = fall_found ? mom_field(r_fall_val) : '0;
                f_found = fall_found;
            end
            default: begin
                f_pos   = peak_found ? r_peak_pos : '0;
                f_sum   = peak_found ? sum_field(r_peak_val) : '0;
                f_mom   = '0;
                f_found = peak_found;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_kind  <= r_cur;
            r_o_pos   <= f_pos;
            r_o_sum   <= f_sum;
            r_o_mom   <= f_mom;
            r_o_found <= f_found;
            r_o_end   <= s2_done;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_kind       = r_o_kind;
    assign o_position   = r_o_pos;
    assign o_window_sum = r_o_sum;
    assign o_moment     = r_o_mom;
    assign o_found      = r_o_found;
    assign o_run_end    = r_o_end;

    // Checks
    a_s2_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_filt || r_s2_last))
        else $error("stage 2 holds an item that causes no result");

    a_report_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && (r_cur != KIND_FILT)) |-> r_s2_last)
        else $error("report sequenced for an item that does not end the scan");

    a_trackers_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_cur == KIND_PEAK)) |=> (!r_rise_v && !r_fall_v && !r_peak_v))
        else $error("trackers not cleared after the peak report");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(WIN_LEN - 1))
        else $error("window pointer out of range");

endmodule

// ----- bench/tb_sliding_linear_fit_peak_finder_unit.sv -----
// Testbench for the sliding linear-fit peak finder: scans in, filter outputs and reports checked.
`timescale 1ns / 100ps

module tb_sliding_linear_fit_peak_finder_unit;
    import slfpf_pkg::*;

    localparam int HALF_W      = 8;
    localparam int WIN_N       = 2 * HALF_W + 1;
    localparam int RANDOM_ITEMS = 90;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;

    // Sample shapes of a random scan
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_BUMP,
        SHAPE_RAIL,
        SHAPE_TWIN_BUMP
    } t_shape;

    typedef struct {
        t_kind               kind;
        logic [POS_W-1:0]    position;
        logic [SUM_OUT_W-1:0] window_sum;
        logic [MOM_OUT_W-1:0] moment;
        logic                found;
        logic                run_end;
    } t_fit_result;

    typedef struct {
        logic [IN_W-1:0] sample;
        logic [IN_W-1:0] scan_offset;
        logic            last;
        bit              empty_reports;
    } t_stim_row;

    typedef struct {
        bit               valid;
        logic [POS_W-1:0] pos;
        longint           value;
    } t_best_point;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [IN_W-1:0]      i_sample = '0;
    logic [IN_W-1:0]      i_scan_offset = '0;
    logic                 i_last = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [1:0]           o_kind;
    logic [POS_W-1:0]     o_position;
    logic [SUM_OUT_W-1:0] o_window_sum;
    logic [MOM_OUT_W-1:0] o_moment;
    logic                 o_found;
    logic                 o_run_end;

    sliding_linear_fit_peak_finder_unit #(
        .HALF_WIDTH (HALF_W),
        .SAMPLE_BITS(16)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_scan_offset(i_scan_offset),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_position   (o_position),
        .o_window_sum (o_window_sum),
        .o_moment     (o_moment),
        .o_found      (o_found),
        .o_run_end    (o_run_end)
    );

    always #1 i_clk = ~i_clk;

    // Expected results, oldest first
    t_fit_result expected_results[$];

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int scans_sent    = 0;
    int reports_found = 0;
    int cycle_count   = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    // Predictor state
    logic [IN_W-1:0]  win_data [WIN_N];
    longint           win_sum;
    longint           win_moment;
    longint           prev_moment;
    int               win_fill;
    logic [POS_W-1:0] center_pos;
    t_best_point      rise_pt;
    t_best_point      fall_pt;
    t_best_point      peak_pt;

    task automatic clear_fit_state();
        for (int k = 0; k < WIN_N; k++) win_data[k] = '0;
        win_sum     = 0;
        win_moment  = 0;
        prev_moment = 0;
        win_fill    = 0;
        center_pos  = '0;
        rise_pt     = '{default: 0};
        fall_pt     = '{default: 0};
        peak_pt     = '{default: 0};
    endtask

    function automatic t_fit_result make_result(t_kind kind, logic [POS_W-1:0] pos,
                                                longint sum, longint mom, logic found);
        t_fit_result r;
        r.kind       = kind;
        r.position   = pos;
        r.window_sum = sum[SUM_OUT_W-1:0];
        r.moment     = mom[MOM_OUT_W-1:0];
        r.found      = found;
        r.run_end    = 1'b0;
        return r;
    endfunction

    // Advance the window by one sample; queue its results when record is set
    task automatic fit_step(logic [IN_W-1:0] x, logic [IN_W-1:0] offs, logic is_last,
                            bit record);
        t_fit_result step_res[$];
        longint      lo;
        longint      hi;
        bit          fr;
        bit          ff;
        bit          fp;
        if (win_fill == 0) center_pos = offs + POS_W'(HALF_W);
        if (win_fill < WIN_N) begin
            win_data[win_fill] = x;
            win_fill++;
            // Full window: build both sums from scratch
            if (win_fill == WIN_N) begin
                win_sum    = win_data[HALF_W];
                win_moment = 0;
                for (int k = 1; k <= HALF_W; k++) begin
                    hi = win_data[HALF_W + k];
                    lo = win_data[HALF_W - k];
                    win_sum    += hi + lo;
                    win_moment += k * (hi - lo);
                end
            end
        end else begin
            lo = win_data[0];
            hi = x;
            for (int k = 0; k < WIN_N - 1; k++) win_data[k] = win_data[k + 1];
            win_data[WIN_N - 1] = x;
            prev_moment = win_moment;
            win_moment += HALF_W * (hi + lo) - (win_sum - lo);
            win_sum    += hi - lo;
            center_pos  = center_pos + 1'b1;
            step_res.push_back(make_result(KIND_FILT, center_pos, win_sum, win_moment, 1'b0));
            // Update the trackers; ties keep the earlier point
            if (!rise_pt.valid || win_moment > rise_pt.value)
                rise_pt = '{1'b1, center_pos, win_moment};
            if (!fall_pt.valid || win_moment < fall_pt.value)
                fall_pt = '{1'b1, center_pos, win_moment};
            if (win_moment < 0 && prev_moment > 0) begin
                if (!peak_pt.valid || win_sum > peak_pt.value)
                    peak_pt = '{1'b1, center_pos, win_sum};
            end
        end
        if (is_last) begin
            fr = rise_pt.valid && rise_pt.value > 0;
            ff = fall_pt.valid && fall_pt.value < 0;
            fp = peak_pt.valid && peak_pt.value > 0;
            step_res.push_back(make_result(KIND_RISE, fr ? rise_pt.pos : '0, 0,
                                           fr ? rise_pt.value : 0, fr));
            step_res.push_back(make_result(KIND_FALL, ff ? fall_pt.pos : '0, 0,
                                           ff ? fall_pt.value : 0, ff));
            step_res.push_back(make_result(KIND_PEAK, fp ? peak_pt.pos : '0,
                                           fp ? peak_pt.value : 0, 0, fp));
            reports_found += int'(fr) + int'(ff) + int'(fp);
            clear_fit_state();
        end
        if (step_res.size() > 0) step_res[step_res.size() - 1].run_end = 1'b1;
        if (record) begin
            foreach (step_res[k]) expected_results.push_back(step_res[k]);
        end
    endtask

    // Wait count for one item: mostly random, now and then a stretch of zero waits
    function automatic int pick_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
        return $urandom_range(0, 10);
    endfunction

    // Offer one item, hold it until accepted, then predict
    int send_calm = 0;
    task automatic send_item(t_stim_row row);
        int gap;
        gap = pick_wait(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= row.sample;
        i_scan_offset <= row.scan_offset;
        i_last        <= row.last;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (row.last) scans_sent++;
        fit_step(row.sample, row.scan_offset, row.last, !row.empty_reports);
        // Scan ended with no filter output: three empty reports
        if (row.empty_reports && row.last) begin
            expected_results.push_back(make_result(KIND_RISE, '0, 0, 0, 1'b0));
            expected_results.push_back(make_result(KIND_FALL, '0, 0, 0, 1'b0));
            expected_results.push_back(make_result(KIND_PEAK, '0, 0, 0, 1'b0));
            expected_results[expected_results.size() - 1].run_end = 1'b1;
        end
    endtask

    function automatic logic [IN_W-1:0] shape_sample(t_shape shape, int i, int c, int w,
                                                     int h, int base);
        longint v;
        int     d;
        case (shape)
            SHAPE_NOISE: v = $urandom_range(0, 65535);
            SHAPE_RAIL:  v = $urandom_range(0, 1) ? 65535 : 0;
            default: begin
                v = base + $urandom_range(0, 31);
                d = (i > c) ? i - c : c - i;
                if (d < w) v += longint'(h) * (w - d);
                if (shape == SHAPE_TWIN_BUMP) begin
                    d = (i > c + 2 * w) ? i - c - 2 * w : c + 2 * w - i;
                    if (d < w) v += longint'(h / 2) * (w - d);
                end
            end
        endcase
        if (v > 65535) v = 65535;
        return v[IN_W-1:0];
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        $display("[%0t] mismatch on %0s: expected %0h, got %0h (result %0d)",
                 $realtime, what, want, got, results_seen);
        error_count++;
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_fit_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, kind", -1, o_kind);
            end else begin
                want = expected_results.pop_front();
                if (o_kind !== want.kind) report_mismatch("kind", want.kind, o_kind);
                if (o_position !== want.position)
                    report_mismatch("position", want.position, o_position);
                if (o_window_sum !== want.window_sum)
                    report_mismatch("window_sum", want.window_sum, o_window_sum);
                if (o_moment !== want.moment)
                    report_mismatch("moment", want.moment, o_moment);
                if (o_found !== want.found) report_mismatch("found", want.found, o_found);
                if (o_run_end !== want.run_end)
                    report_mismatch("run_end", want.run_end, o_run_end);
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int wait_n;
        int sink_calm;
        sink_calm = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                wait_n = pick_wait(sink_calm);
                if (wait_n > 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Stimulus
    initial begin : sample_source
        t_stim_row dir_rows[$];
        t_stim_row row;
        int        scan_len;
        t_shape    shape;
        int        bump_c;
        int        bump_w;
        int        bump_h;
        int        bump_base;
        int        rand_scans;

        clear_fit_state();
        rand_scans = 0;

        // Single last sample right after reset: empty reports
        dir_rows.push_back('{16'h0000, 16'h0000, 1'b1, 1'b1});
        // Full-scale window that ends on its initializing sample; later offsets ignored
        for (int k = 0; k < WIN_N; k++)
            dir_rows.push_back('{16'hFFFF, (k == 0) ? 16'hFFFF : 16'h0000,
                                 (k == WIN_N - 1), 1'b1});
        // Short scan ended before the window fills
        dir_rows.push_back('{16'h5555, 16'h8000, 1'b0, 1'b1});
        dir_rows.push_back('{16'hAAAA, 16'h7FFF, 1'b0, 1'b1});
        dir_rows.push_back('{16'h0001, 16'h1234, 1'b1, 1'b1});

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send_item(dir_rows[k]);

        // Random scans: mostly long shaped ones, a few short or init-only
        while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       scan_len = $urandom_range(1, WIN_N - 1);
                1:       scan_len = WIN_N;
                default: scan_len = $urandom_range(WIN_N + 1, 45);
            endcase
            // Keep the held-off scan long so the block backs up
            if (rand_scans == 1) scan_len = 45;
            shape     = t_shape'($urandom_range(0, 3));
            bump_w    = $urandom_range(2, 10);
            bump_c    = $urandom_range(0, scan_len - 1);
            bump_h    = $urandom_range(1, 6000);
            bump_base = $urandom_range(0, 1) ? $urandom_range(0, 200)
                                             : $urandom_range(0, 65535);
            rand_scans++;
            // Pause until everything queued has come out
            if (rand_scans == 4) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            for (int i = 0; i < scan_len; i++) begin
                if (rand_scans == 2 && i == WIN_N + 2) hold_req = 1'b1;
                row.sample        = shape_sample(shape, i, bump_c, bump_w, bump_h, bump_base);
                row.scan_offset   = $urandom_range(0, 65535);
                row.last          = (i == scan_len - 1);
                row.empty_reports = 1'b0;
                send_item(row);
            end
        end
        i_valid <= 1'b0;

        // Drain, then let the pipeline settle
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples in %0d scans; checked %0d results, %0d reports found.",
                 items_sent, scans_sent, results_seen, reports_found);
        $display("Covered empty scans, full-scale windows, offset wrap and stall pressure.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
